>>> hdl/stkshp_pkg.sv
// ----------------------------------------------------------------------------
// Stick shaper package
// Shared widths, constants, codes and control types of the two-axis stick
// shaper and its lanes.
// ----------------------------------------------------------------------------
package stkshp_pkg;

	// Default tick divider.
	localparam int TICK_DIVIDE_DEF = 4;

	// Field and datapath widths.
	localparam int SAMP_W   = 16;  // stick sample
	localparam int OUT_W    = 17;  // shaped command
	localparam int LAST_W   = 18;  // held command, holds -32768 .. 65535
	localparam int RAMP_W   = 19;  // hat ramp sum and signed gain result
	localparam int MAG_W    = 17;  // magnitude before gain, up to 32768
	localparam int PCT_W    = 7;
	localparam int GAIN_W   = 9;
	localparam int DZP_W    = 23;  // dead zone percent times cal maximum
	localparam int PROD_W   = 26;  // magnitude times gain
	localparam int QUO_W    = 18;  // gained magnitude after divide by 100
	localparam int SRC_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 40;

	// Divide by 100 through a reciprocal: q = (m * RECIP) >> RECIP_SHIFT.
	// Exact for m below 2^24, which covers 32768 * 511.
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 31;
	localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;
	localparam logic [DZP_W-1:0]   PCT_SCALE = 23'd100;

	// Hat ramp step and the fixed bound for the hat source.
	localparam logic signed [RAMP_W-1:0] HAT_STEP  = 19'sd983;
	localparam logic signed [RAMP_W-1:0] HAT_LIMIT = 19'sd32768;

	// Source codes.
	localparam logic [SRC_W-1:0] SRC_HAT    = 2'd0;
	localparam logic [SRC_W-1:0] SRC_AXES01 = 2'd1;
	localparam logic [SRC_W-1:0] SRC_AXES23 = 2'd2;
	localparam logic [SRC_W-1:0] SRC_NONE   = 2'd3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_SOURCE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_PCT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PCT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_CAL_MIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_CAL_MAX  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_CAL_MIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_CAL_MAX = 3'd6;

	// Register reset values.
	localparam logic [GAIN_W-1:0] GAIN_RST = 9'd100;
	localparam logic [SAMP_W-1:0] CAL_MIN_RST = 16'h8000;
	localparam logic [SAMP_W-1:0] CAL_MAX_RST = 16'h8000;

	// Pipeline control shared by both lanes.
	typedef struct packed {
		logic adv;     // all stages move one step
		logic commit;  // last stage holds a result that leaves this cycle
	} lane_ctrl_t;

	// Per-lane view of the configuration.
	typedef struct packed {
		logic                     hat_mode;
		logic [GAIN_W-1:0]        gain;
		logic [DZP_W-1:0]         dz_prod;
		logic signed [SAMP_W-1:0] cal_min;
		logic [SAMP_W-1:0]        cal_max;
	} lane_cfg_t;

endpackage

>>> hdl/two_axis_stick_shaper_top.sv
// ----------------------------------------------------------------------------
// Two-axis stick shaper
// Channel    Dir  Handshake                     Contents
// s_axis     in   s_axis_tvalid/s_axis_tready   one tick: axes, hats, enable
// m_axis     out  m_axis_tvalid/m_axis_tready   roll and pitch commands
// cfg        in   cfg_valid/cfg_ready           register index and data
//
// A tick is taken every cycle unless the buffer is full or a hat tick waits.
// A due tick runs through four lane stages into a two-word output buffer.
// With the hat source and TICK_DIVIDE below 4, a due tick waits for the
// previous result to reach the held command in the lanes.
// When both buffer words wait on m_axis, the lanes and s_axis stall.
// Reset is asynchronous and needs no sweep; cfg_ready is always high.
// ----------------------------------------------------------------------------
module two_axis_stick_shaper_top #(
	parameter int TICK_DIVIDE = stkshp_pkg::TICK_DIVIDE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [15:0] axis_zero, [31:16] axis_one, [47:32] axis_two, [63:48] axis_three,
	// [64] hat_up, [65] hat_down, [66] hat_left, [67] hat_right, rest zero
	input  logic [stkshp_pkg::S_DATA_W-1:0]      s_axis_tdata,
	// [0] enable
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [16:0] roll_out, [33:17] pitch_out, rest zero
	output logic [stkshp_pkg::M_DATA_W-1:0]      m_axis_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [stkshp_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [stkshp_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import stkshp_pkg::*;

	localparam int TICK_W = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;
	localparam logic [TICK_W-1:0] TICK_DUE = TICK_W'(TICK_DIVIDE - 1);

	logic [SRC_W-1:0]  src_q;
	logic [PCT_W-1:0]  pct_q;
	logic [GAIN_W-1:0] gain_q;
	logic [SAMP_W-1:0] roll_min_q;
	logic [SAMP_W-1:0] roll_max_q;
	logic [SAMP_W-1:0] pitch_min_q;
	logic [SAMP_W-1:0] pitch_max_q;
	logic [DZP_W-1:0]  roll_dzp_q;
	logic [DZP_W-1:0]  pitch_dzp_q;
	logic [TICK_W-1:0] tick_q;
	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic              v_s4;

	logic              cfg_wr;
	logic              accept;
	logic              due;
	logic              hazard;
	logic              load;
	logic              space;
	logic              axes23;
	lane_ctrl_t        ctrl;
	lane_cfg_t         roll_cfg;
	lane_cfg_t         pitch_cfg;
	logic signed [SAMP_W-1:0] roll_samp;
	logic signed [SAMP_W-1:0] pitch_samp;
	logic signed [OUT_W-1:0]  roll_res;
	logic signed [OUT_W-1:0]  pitch_res;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q       <= SRC_HAT;
			pct_q       <= '0;
			gain_q      <= GAIN_RST;
			roll_min_q  <= CAL_MIN_RST;
			roll_max_q  <= CAL_MAX_RST;
			pitch_min_q <= CAL_MIN_RST;
			pitch_max_q <= CAL_MAX_RST;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_AXIS_SOURCE:   src_q       <= cfg_data[SRC_W-1:0];
				REG_DEADZONE_PCT:  pct_q       <= cfg_data[PCT_W-1:0];
				REG_GAIN_PCT:      gain_q      <= cfg_data[GAIN_W-1:0];
				REG_ROLL_CAL_MIN:  roll_min_q  <= cfg_data;
				REG_ROLL_CAL_MAX:  roll_max_q  <= cfg_data;
				REG_PITCH_CAL_MIN: pitch_min_q <= cfg_data;
				REG_PITCH_CAL_MAX: pitch_max_q <= cfg_data;
				default:           src_q       <= src_q;
			endcase
		end
	end

	// Dead zone products follow the registers in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_dzp_q  <= '0;
			pitch_dzp_q <= '0;
		end else begin
			roll_dzp_q  <= DZP_W'(pct_q) * DZP_W'(roll_max_q);
			pitch_dzp_q <= DZP_W'(pct_q) * DZP_W'(pitch_max_q);
		end
	end

	// The buffer's free space gates every stage.
	assign ctrl.adv = space;

	// Handshake: a due hat tick waits while an earlier result is still
	// ahead of the last stage, since it ramps from that result.
	assign due           = (tick_q == TICK_DUE);
	assign hazard        = due && (src_q == SRC_HAT) && (v_s1 || v_s2 || v_s3);
	assign s_axis_tready = ctrl.adv & ~hazard;
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign load          = accept && s_axis_tuser && due && (src_q != SRC_NONE);

	// Tick divider; it holds at the due count while the source emits nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (accept && s_axis_tuser) begin
			if (!due) begin
				tick_q <= tick_q + TICK_W'(1);
			end else if (src_q != SRC_NONE) begin
				tick_q <= '0;
			end
		end
	end

	// Valid bits of the lane stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (ctrl.adv) begin
			v_s1 <= load;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign ctrl.commit = v_s4 & ctrl.adv;

	// Lane inputs.
	assign axes23     = (src_q == SRC_AXES23);
	assign roll_samp  = axes23 ? s_axis_tdata[47:32] : s_axis_tdata[15:0];
	assign pitch_samp = axes23 ? s_axis_tdata[63:48] : s_axis_tdata[31:16];

	assign roll_cfg.hat_mode  = (src_q == SRC_HAT);
	assign roll_cfg.gain      = gain_q;
	assign roll_cfg.dz_prod   = roll_dzp_q;
	assign roll_cfg.cal_min   = roll_min_q;
	assign roll_cfg.cal_max   = roll_max_q;
	assign pitch_cfg.hat_mode = (src_q == SRC_HAT);
	assign pitch_cfg.gain     = gain_q;
	assign pitch_cfg.dz_prod  = pitch_dzp_q;
	assign pitch_cfg.cal_min  = pitch_min_q;
	assign pitch_cfg.cal_max  = pitch_max_q;

	// Roll lane: left decreases, right increases.
	stkshp_lane u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (roll_cfg),
		.sample (roll_samp),
		.dec    (s_axis_tdata[66]),
		.inc    (s_axis_tdata[67]),
		.result (roll_res)
	);

	// Pitch lane: up decreases, down increases.
	stkshp_lane u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (pitch_cfg),
		.sample (pitch_samp),
		.dec    (s_axis_tdata[64]),
		.inc    (s_axis_tdata[65]),
		.result (pitch_res)
	);

	// Merge the lanes into the output buffer.
	stkshp_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (ctrl.commit),
		.roll_in       (roll_res),
		.pitch_in      (pitch_res),
		.space         (space),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

>>> hdl/stkshp_lane.sv
// ----------------------------------------------------------------------------
// Stick shaper lane
// One channel: hat ramp or dead zone, gain in percent, clamp, and the held
// last command. Four stages; the held command updates as a result leaves.
// ----------------------------------------------------------------------------
module stkshp_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stkshp_pkg::lane_ctrl_t            ctrl,
	input  stkshp_pkg::lane_cfg_t             cfg,
	input  logic signed [stkshp_pkg::SAMP_W-1:0] sample,
	input  logic                              dec,
	input  logic                              inc,
	output logic signed [stkshp_pkg::OUT_W-1:0]  result
);
	import stkshp_pkg::*;

	logic signed [SAMP_W-1:0] samp_s1;
	logic                     dec_s1;
	logic                     inc_s1;
	logic                     neg_s2;
	logic [MAG_W-1:0]         mag_s2;
	logic                     neg_s3;
	logic [PROD_W-1:0]        prod_s3;
	logic                     neg_s4;
	logic [QUO_W-1:0]         quo_s4;
	logic signed [LAST_W-1:0] last_q;

	logic signed [RAMP_W-1:0] last_x;
	logic signed [RAMP_W-1:0] ramp_sum;
	logic signed [RAMP_W-1:0] ramp_v;
	logic signed [RAMP_W-1:0] samp_x;
	logic [MAG_W-1:0]         samp_mag;
	logic [DZP_W-1:0]         zone_thr;
	logic                     in_zone;
	logic signed [RAMP_W-1:0] sel_v;
	logic signed [RAMP_W-1:0] sel_abs;
	logic [PROD_W+RECIP_W-1:0] recip_prod;
	logic signed [RAMP_W-1:0] gained;
	logic signed [RAMP_W-1:0] hi_bound;
	logic signed [RAMP_W-1:0] lo_bound;
	logic signed [RAMP_W-1:0] clamped;

	// Stage 1 captures the word fields.
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			samp_s1 <= sample;
			dec_s1  <= dec;
			inc_s1  <= inc;
		end
	end

	// Hat ramp from the held command, or zero with no hat pressed, clamped to the fixed limit.
	always_comb begin
		last_x = RAMP_W'(last_q);
		if (dec_s1) begin
			ramp_sum = last_x - HAT_STEP;
		end else if (inc_s1) begin
			ramp_sum = last_x + HAT_STEP;
		end else begin
			ramp_sum = '0;
		end
		ramp_v = ramp_sum;
		if (ramp_v > HAT_LIMIT) begin
			ramp_v = HAT_LIMIT;
		end
		if (ramp_v < -HAT_LIMIT) begin
			ramp_v = -HAT_LIMIT;
		end
	end

	// Dead zone: |v| < floor(P / 100) is the same as 100 * (|v| + 1) <= P.
	always_comb begin
		samp_x   = RAMP_W'(samp_s1);
		samp_mag = samp_s1[SAMP_W-1] ? MAG_W'(-samp_x) : MAG_W'(samp_x);
		zone_thr = (DZP_W'(samp_mag) + DZP_W'(1)) * PCT_SCALE;
		in_zone  = (zone_thr <= cfg.dz_prod);
		if (cfg.hat_mode) begin
			sel_v = ramp_v;
		end else if (in_zone) begin
			sel_v = '0;
		end else begin
			sel_v = samp_x;
		end
		sel_abs = sel_v[RAMP_W-1] ? -sel_v : sel_v;
	end

	// Stage 2 holds sign and magnitude.
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			neg_s2 <= sel_v[RAMP_W-1];
			mag_s2 <= sel_abs[MAG_W-1:0];
		end
	end

	// Stage 3 holds magnitude times gain.
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			neg_s3  <= neg_s2;
			prod_s3 <= PROD_W'(mag_s2) * PROD_W'(cfg.gain);
		end
	end

	// Stage 4 holds the product divided by 100.
	assign recip_prod = (PROD_W+RECIP_W)'(prod_s3) * (PROD_W+RECIP_W)'(RECIP_100);

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			neg_s4 <= neg_s3;
			quo_s4 <= recip_prod[RECIP_SHIFT +: QUO_W];
		end
	end

	// Restore the sign, then the upper bound and the lower bound last.
	always_comb begin
		gained   = neg_s4 ? -$signed({1'b0, quo_s4}) : $signed({1'b0, quo_s4});
		hi_bound = cfg.hat_mode ? HAT_LIMIT : $signed(RAMP_W'(cfg.cal_max));
		lo_bound = cfg.hat_mode ? -HAT_LIMIT : RAMP_W'(cfg.cal_min);
		clamped  = gained;
		if (clamped > hi_bound) begin
			clamped = hi_bound;
		end
		if (clamped < lo_bound) begin
			clamped = lo_bound;
		end
	end

	assign result = clamped[OUT_W-1:0];

	// Held command for the hat ramp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (ctrl.commit) begin
			last_q <= clamped[LAST_W-1:0];
		end
	end

endmodule

>>> hdl/stkshp_outbuf.sv
// ----------------------------------------------------------------------------
// Stick shaper output buffer
// Merges the two lane results into one word and holds up to two words, so
// the lanes keep moving while a word waits on the master side.
// ----------------------------------------------------------------------------
module stkshp_outbuf (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic signed [stkshp_pkg::OUT_W-1:0] roll_in,
	input  logic signed [stkshp_pkg::OUT_W-1:0] pitch_in,
	output logic                              space,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [stkshp_pkg::M_DATA_W-1:0]   m_axis_tdata
);
	import stkshp_pkg::*;

	localparam int PAY_W = 2 * OUT_W;

	logic [1:0]       cnt_q;
	logic [PAY_W-1:0] head_q;
	logic [PAY_W-1:0] skid_q;
	logic [PAY_W-1:0] merged;
	logic             pop;

	assign merged        = {pitch_in, roll_in};
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = M_DATA_W'(head_q);
	assign pop           = m_axis_tvalid & m_axis_tready;
	assign space         = (cnt_q != 2'd2);

	// Word count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Head and skid words.
	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (push) begin
					head_q <= merged;
				end
			end
			2'd1: begin
				if (push && pop) begin
					head_q <= merged;
				end else if (push) begin
					skid_q <= merged;
				end
			end
			2'd2: begin
				if (pop) begin
					head_q <= skid_q;
				end
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

endmodule
